// ----- design/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define CLLE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, off during reset.
`define CLLE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/clle_pkg.sv -----
// Types, constants and helpers of the cursor linked list engine.
`default_nettype none

package clle_pkg;

  localparam int POOL_DEPTH    = 256;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int IDX_W         = $clog2(POOL_DEPTH);
  localparam int LINK_W        = IDX_W + 1;
  localparam int COUNT_W       = $clog2(POOL_DEPTH + 1);
  localparam int OP_W          = 3;

  localparam logic [LINK_W-1:0]  NIL      = LINK_W'(POOL_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(POOL_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_HEAD       = 3'd0,
    OP_TAIL       = 3'd1,
    OP_CURRENT    = 3'd2,
    OP_NEXT       = 3'd3,
    OP_PREV       = 3'd4,
    OP_INS_AFTER  = 3'd5,
    OP_INS_BEFORE = 3'd6,
    OP_REMOVE     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_WR_NEW,
    ST_WR_LINK,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic [PAYLOAD_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]         raddr;
  } pay_req_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } link_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } free_req_t;

  typedef struct packed {
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic                     valid;
    logic [COUNT_W-1:0]       count;
    logic                     status;
  } result_t;

  function automatic logic is_live(input logic [LINK_W-1:0] idx);
    return idx < NIL;
  endfunction

endpackage

`default_nettype wire

// ----- design/clle_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module clle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/clle_ctrl.sv -----
// Sequencer: cursor cache, list registers, free pool and memory requests.
`default_nettype none

module clle_ctrl import clle_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_W-1:0]          operation,
  input  wire logic [PAYLOAD_WIDTH-1:0] payload_in,
  input  wire logic                     obuf_full,
  output pay_req_t                      pay_req,
  output link_req_t                     next_req,
  output link_req_t                     prev_req,
  output free_req_t                     free_req,
  input  wire logic [PAYLOAD_WIDTH-1:0] pay_rdata,
  input  wire logic [LINK_W-1:0]        next_rdata,
  input  wire logic [LINK_W-1:0]        prev_rdata,
  input  wire logic [IDX_W-1:0]         free_rdata,
  output logic                          push,
  output result_t                       res
);

  state_t                   state, state_next;
  op_t                      op, op_in;
  logic [PAYLOAD_WIDTH-1:0] data;
  logic [IDX_W-1:0]         load_idx;
  logic [IDX_W-1:0]         alloc_idx;
  logic [LINK_W-1:0]        head, tail, cursor;
  logic [PAYLOAD_WIDTH-1:0] cur_payload;
  logic [LINK_W-1:0]        cur_next, cur_prev;
  logic [COUNT_W-1:0]       count, stack_top, fresh;

  logic              acc, full, is_ins, ins_go, rm_go, load_go;
  logic [LINK_W-1:0] tgt;
  logic [COUNT_W-1:0] stack_dec;

  assign op_in     = op_t'(operation);
  assign in_stall  = (state != ST_IDLE) || obuf_full;
  assign acc       = in_valid && !in_stall;
  assign full      = (count == COUNT_FULL);
  assign is_ins    = (op_in == OP_INS_AFTER) || (op_in == OP_INS_BEFORE);
  assign ins_go    = is_ins && !full;
  assign rm_go     = (op_in == OP_REMOVE) && is_live(cursor);
  assign stack_dec = stack_top - COUNT_W'(1);

  // Decode the entry an operation moves the cursor to.
  always_comb begin
    tgt = NIL;
    case (op_in)
      OP_HEAD: tgt = head;
      OP_TAIL: tgt = tail;
      OP_NEXT: tgt = is_live(cursor) ? cur_next : NIL;
      OP_PREV: tgt = is_live(cursor) ? cur_prev : NIL;
      OP_REMOVE: begin
        if (is_live(cursor)) begin
          tgt = is_live(cur_next) ? cur_next : cur_prev;
        end
      end
      default: tgt = NIL;
    endcase
  end

  assign load_go = is_live(tgt);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (load_go) begin
            state_next = ST_LOAD;
          end else if (ins_go) begin
            state_next = (stack_top != '0) ? ST_POP : ST_WR_NEW;
          end
        end
      end
      ST_POP:     state_next = ST_WR_NEW;
      ST_WR_NEW:  state_next = is_live(cursor) ? ST_WR_LINK : ST_IDLE;
      ST_WR_LINK: state_next = ST_IDLE;
      ST_LOAD:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pay_req        = '0;
    next_req       = '0;
    prev_req       = '0;
    free_req       = '0;
    pay_req.raddr  = tgt[IDX_W-1:0];
    next_req.raddr = tgt[IDX_W-1:0];
    prev_req.raddr = tgt[IDX_W-1:0];
    free_req.raddr = stack_dec[IDX_W-1:0];
    push           = 1'b0;
    res            = '0;
    case (state)
      ST_IDLE: begin
        if (acc && rm_go) begin
          // Unlink the cursor entry and return it to the free stack.
          next_req.we    = is_live(cur_prev);
          next_req.waddr = cur_prev[IDX_W-1:0];
          next_req.wdata = cur_next;
          prev_req.we    = is_live(cur_next);
          prev_req.waddr = cur_next[IDX_W-1:0];
          prev_req.wdata = cur_prev;
          free_req.we    = 1'b1;
          free_req.waddr = stack_top[IDX_W-1:0];
          free_req.wdata = cursor[IDX_W-1:0];
        end
        if (acc && !load_go && !ins_go) begin
          push       = 1'b1;
          res.count  = rm_go ? (count - COUNT_W'(1)) : count;
          res.status = is_ins;
          if (((op_in == OP_CURRENT) || is_ins) && is_live(cursor)) begin
            res.valid   = 1'b1;
            res.payload = cur_payload;
          end
        end
      end
      ST_WR_NEW: begin
        pay_req.we     = 1'b1;
        pay_req.waddr  = alloc_idx;
        pay_req.wdata  = data;
        next_req.we    = 1'b1;
        next_req.waddr = alloc_idx;
        prev_req.we    = 1'b1;
        prev_req.waddr = alloc_idx;
        if (!is_live(cursor)) begin
          next_req.wdata = NIL;
          prev_req.wdata = NIL;
          push           = 1'b1;
          res.payload    = data;
          res.valid      = 1'b1;
          res.count      = count + COUNT_W'(1);
        end else if (op == OP_INS_AFTER) begin
          next_req.wdata = cur_next;
          prev_req.wdata = cursor;
        end else begin
          next_req.wdata = cursor;
          prev_req.wdata = cur_prev;
        end
      end
      ST_WR_LINK: begin
        if (op == OP_INS_AFTER) begin
          next_req.we    = 1'b1;
          next_req.waddr = cursor[IDX_W-1:0];
          next_req.wdata = {1'b0, alloc_idx};
          prev_req.we    = is_live(cur_next);
          prev_req.waddr = cur_next[IDX_W-1:0];
          prev_req.wdata = {1'b0, alloc_idx};
        end else begin
          prev_req.we    = 1'b1;
          prev_req.waddr = cursor[IDX_W-1:0];
          prev_req.wdata = {1'b0, alloc_idx};
          next_req.we    = is_live(cur_prev);
          next_req.waddr = cur_prev[IDX_W-1:0];
          next_req.wdata = {1'b0, alloc_idx};
        end
        push        = 1'b1;
        res.payload = data;
        res.valid   = 1'b1;
        res.count   = count + COUNT_W'(1);
      end
      ST_LOAD: begin
        push        = 1'b1;
        res.payload = pay_rdata;
        res.valid   = 1'b1;
        res.count   = count;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= NIL;
      tail      <= NIL;
      cursor    <= NIL;
      count     <= '0;
      stack_top <= '0;
      fresh     <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (acc) begin
            op       <= op_in;
            data     <= payload_in;
            load_idx <= tgt[IDX_W-1:0];
            if (ins_go) begin
              if (stack_top == '0) begin
                alloc_idx <= fresh[IDX_W-1:0];
                fresh     <= fresh + COUNT_W'(1);
              end else begin
                stack_top <= stack_dec;
              end
            end
            if (rm_go) begin
              stack_top <= stack_top + COUNT_W'(1);
              count     <= count - COUNT_W'(1);
              if (!is_live(cur_prev)) begin
                head <= is_live(cur_next) ? cur_next : NIL;
              end
              if (!is_live(cur_next)) begin
                tail <= is_live(cur_prev) ? cur_prev : NIL;
              end
              if (!load_go) begin
                cursor <= NIL;
              end
            end
          end
        end
        ST_POP: begin
          alloc_idx <= free_rdata;
        end
        ST_WR_NEW: begin
          if (!is_live(cursor)) begin
            head        <= {1'b0, alloc_idx};
            tail        <= {1'b0, alloc_idx};
            cursor      <= {1'b0, alloc_idx};
            cur_payload <= data;
            cur_next    <= NIL;
            cur_prev    <= NIL;
            count       <= count + COUNT_W'(1);
          end
        end
        ST_WR_LINK: begin
          cursor      <= {1'b0, alloc_idx};
          cur_payload <= data;
          count       <= count + COUNT_W'(1);
          if (op == OP_INS_AFTER) begin
            cur_prev <= cursor;
            if (!is_live(cur_next)) begin
              tail <= {1'b0, alloc_idx};
            end
          end else begin
            cur_next <= cursor;
            if (!is_live(cur_prev)) begin
              head <= {1'b0, alloc_idx};
            end
          end
        end
        ST_LOAD: begin
          cursor      <= {1'b0, load_idx};
          cur_payload <= pay_rdata;
          // After a remove the link toward the removed entry was read stale.
          if (!((op == OP_REMOVE) && is_live(cur_next))) begin
            cur_prev <= prev_rdata;
          end
          if (!((op == OP_REMOVE) && !is_live(cur_next))) begin
            cur_next <= next_rdata;
          end
        end
        default: begin
          cursor <= cursor;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/clle_obuf.sv -----
// Two-entry result buffer: output register plus one skid entry.
`default_nettype none

module clle_obuf import clle_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t res,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      out_res,
  output logic         full
);

  result_t pend;
  logic    out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full      <= 1'b0;
    end else if (out_free) begin
      out_valid <= full || push;
      out_res   <= full ? pend : res;
      full      <= 1'b0;
    end else if (push) begin
      pend <= res;
      full <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/cursor_linked_list_engine.sv -----
// Current, refused insert and a move or remove with no entry to land on give their result straight
// from idle into the output buffer register; moves and removes that land on an entry first pass
// through the load state (memory read). Insert passes through the write-new and link-write states,
// after a free stack pop state for a recycled entry; into an empty list it ends at write-new.
// A new item is taken only once the sequencer is back in idle and the result buffer is not full.
// Reset clears the list registers and free pool counters; memories are not cleared.
`default_nettype none

module cursor_linked_list_engine import clle_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_W-1:0]          operation,
  input  wire logic [PAYLOAD_WIDTH-1:0] payload_in,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [PAYLOAD_WIDTH-1:0]      payload_out,
  output logic                          payload_valid,
  output logic [COUNT_W-1:0]            element_count,
  output logic                          status
);

  pay_req_t                 pay_req;
  link_req_t                next_req, prev_req;
  free_req_t                free_req;
  logic [PAYLOAD_WIDTH-1:0] pay_rdata;
  logic [LINK_W-1:0]        next_rdata, prev_rdata;
  logic [IDX_W-1:0]         free_rdata;
  logic                     push, obuf_full;
  result_t                  res, out_res;

  clle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .payload_in (payload_in),
    .obuf_full  (obuf_full),
    .pay_req    (pay_req),
    .next_req   (next_req),
    .prev_req   (prev_req),
    .free_req   (free_req),
    .pay_rdata  (pay_rdata),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata),
    .free_rdata (free_rdata),
    .push       (push),
    .res        (res)
  );

  clle_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(POOL_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (pay_req.we),
    .waddr (pay_req.waddr),
    .wdata (pay_req.wdata),
    .raddr (pay_req.raddr),
    .rdata (pay_rdata)
  );

  clle_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (next_req.we),
    .waddr (next_req.waddr),
    .wdata (next_req.wdata),
    .raddr (next_req.raddr),
    .rdata (next_rdata)
  );

  clle_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prev_req.we),
    .waddr (prev_req.waddr),
    .wdata (prev_req.wdata),
    .raddr (prev_req.raddr),
    .rdata (prev_rdata)
  );

  clle_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (free_req.we),
    .waddr (free_req.waddr),
    .wdata (free_req.wdata),
    .raddr (free_req.raddr),
    .rdata (free_rdata)
  );

  clle_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (obuf_full)
  );

  assign payload_out   = out_res.payload;
  assign payload_valid = out_res.valid;
  assign element_count = out_res.count;
  assign status        = out_res.status;

endmodule

`default_nettype wire

// ----- design/clle_checker.sv -----
// Port-level checker for the cursor linked list engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module clle_checker import clle_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [PAYLOAD_WIDTH-1:0] payload_out,
  input wire logic                     payload_valid,
  input wire logic [COUNT_W-1:0]       element_count,
  input wire logic                     status
);

  `CLLE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(payload_out) && $stable(element_count))
  `CLLE_ASSERT_IMP(a_nil_zero, clk, rst, out_valid && !payload_valid, payload_out == '0)
  `CLLE_ASSERT_IMP(a_refuse_full, clk, rst, out_valid && status, element_count == COUNT_FULL)
  `CLLE_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall || out_valid)

endmodule

bind cursor_linked_list_engine clle_checker u_clle_checker (.*);

`default_nettype wire

// ----- sim/tb_cursor_linked_list_engine.sv -----
// Self-checking testbench for the cursor linked list engine: directed and random beats.
`timescale 1ns / 1ps

module tb_cursor_linked_list_engine;
  import clle_pkg::*;

  localparam int DEAD_LIMIT = 2000;

  class list_scoreboard;
    logic [PAYLOAD_WIDTH-1:0] entry_data [POOL_DEPTH];
    logic [LINK_W-1:0]        fwd_link [POOL_DEPTH];
    logic [LINK_W-1:0]        back_link [POOL_DEPTH];
    logic [IDX_W-1:0]         spare_pool [POOL_DEPTH];
    int                       spare_top;
    logic [LINK_W-1:0]        head, tail, cursor;
    int                       length;
    result_t                  expected_q[$];
    int                       errors, beats_in, beats_out, refused, blank, peak;

    function new();
      foreach (spare_pool[i]) spare_pool[i] = IDX_W'(POOL_DEPTH - 1 - i);
      spare_top = POOL_DEPTH;
      head = NIL;
      tail = NIL;
      cursor = NIL;
      length = 0;
      errors = 0;
      beats_in = 0;
      beats_out = 0;
      refused = 0;
      blank = 0;
      peak = 0;
    endfunction

    function void link_in(logic [PAYLOAD_WIDTH-1:0] data, bit after);
      logic [LINK_W-1:0] slot, nb, pb;
      spare_top--;
      slot = {1'b0, spare_pool[spare_top]};
      entry_data[slot] = data;
      if (cursor >= NIL) begin
        fwd_link[slot] = NIL;
        back_link[slot] = NIL;
        head = slot;
        tail = slot;
      end else if (after) begin
        nb = fwd_link[cursor];
        back_link[slot] = cursor;
        fwd_link[slot] = nb;
        if (nb < NIL) back_link[nb] = slot;
        else tail = slot;
        fwd_link[cursor] = slot;
      end else begin
        pb = back_link[cursor];
        fwd_link[slot] = cursor;
        back_link[slot] = pb;
        if (pb < NIL) fwd_link[pb] = slot;
        else head = slot;
        back_link[cursor] = slot;
      end
      cursor = slot;
      length++;
    endfunction

    function void unlink();
      logic [LINK_W-1:0] nb, pb, gone;
      if (cursor >= NIL) return;
      gone = cursor;
      nb = fwd_link[gone];
      pb = back_link[gone];
      if (pb < NIL) fwd_link[pb] = nb;
      else head = nb;
      if (nb < NIL) back_link[nb] = pb;
      else tail = pb;
      cursor = (nb < NIL) ? nb : pb;
      spare_pool[spare_top] = gone[IDX_W-1:0];
      spare_top++;
      length--;
    endfunction

    function void note(op_t op, logic [PAYLOAD_WIDTH-1:0] data);
      result_t r;
      bit shown;
      shown = 1'b1;
      r = '0;
      case (op)
        OP_HEAD:    cursor = head;
        OP_TAIL:    cursor = tail;
        OP_CURRENT: ;
        OP_NEXT: begin
          if (cursor < NIL && fwd_link[cursor] < NIL) cursor = fwd_link[cursor];
          else shown = 1'b0;
        end
        OP_PREV: begin
          if (cursor < NIL && back_link[cursor] < NIL) cursor = back_link[cursor];
          else shown = 1'b0;
        end
        OP_INS_AFTER, OP_INS_BEFORE: begin
          if (length >= POOL_DEPTH || spare_top == 0) begin
            r.status = 1'b1;
            refused++;
          end else begin
            link_in(data, op == OP_INS_AFTER);
          end
        end
        default: unlink();
      endcase
      if (shown && cursor < NIL) begin
        r.payload = entry_data[cursor];
        r.valid = 1'b1;
      end else begin
        blank++;
      end
      r.count = COUNT_W'(length);
      if (length > peak) peak = length;
      beats_in++;
      expected_q.push_back(r);
    endfunction

    function void check(result_t got);
      result_t want;
      beats_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.payload !== want.payload) begin
        $display("%0t: payload_out expected %h got %h", $time, want.payload, got.payload);
        errors++;
      end
      if (got.valid !== want.valid) begin
        $display("%0t: payload_valid expected %b got %b", $time, want.valid, got.valid);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: element_count expected %0d got %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %b got %b", $time, want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          operation = '0;
  logic [PAYLOAD_WIDTH-1:0] payload_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [PAYLOAD_WIDTH-1:0] payload_out;
  logic                     payload_valid;
  logic [COUNT_W-1:0]       element_count;
  logic                     status;

  bit             quiet = 1'b0;
  list_scoreboard sb = new();

  cursor_linked_list_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .payload_in    (payload_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_out   (payload_out),
    .payload_valid (payload_valid),
    .element_count (element_count),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_beat(op_t op, logic [PAYLOAD_WIDTH-1:0] data);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    payload_in <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(op, data);
  endtask

  function automatic op_t pick_op(int ins_pct, int rm_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return $urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE;
    if (roll < ins_pct + rm_pct) return OP_REMOVE;
    return op_t'($urandom_range(0, 4));
  endfunction

  task automatic run_phase(int n, int ins_pct, int rm_pct);
    repeat (n) send_beat(pick_op(ins_pct, rm_pct), $urandom());
  endtask

  always @(posedge clk) begin : result_mon
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.payload = payload_out;
      got.valid = payload_valid;
      got.count = element_count;
      got.status = status;
      sb.check(got);
    end
  end

  initial begin : rx_side
    int hold, taken, last_hold;
    hold = 0;
    taken = 0;
    last_hold = -1;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) taken++;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if ((taken == 60 || taken == 600) && last_hold != taken) begin
        // hold off long enough for the input side to back up
        last_hold = taken;
        hold = 150;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 27);
      end
    end
  end

  initial begin : watchdog
    int dead;
    dead = 0;
    while (dead < DEAD_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) dead = 0;
      else dead++;
    end
    $display("tb_cursor_linked_list_engine failed");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list
    send_beat(OP_HEAD, $urandom());
    send_beat(OP_TAIL, $urandom());
    send_beat(OP_CURRENT, $urandom());
    send_beat(OP_NEXT, $urandom());
    send_beat(OP_PREV, $urandom());
    send_beat(OP_REMOVE, $urandom());
    // build three entries, walk off both ends
    send_beat(OP_INS_AFTER, 32'h0000_0000);
    send_beat(OP_INS_AFTER, 32'hFFFF_FFFF);
    send_beat(OP_INS_BEFORE, 32'hA5A5_A5A5);
    send_beat(OP_NEXT, $urandom());
    send_beat(OP_NEXT, $urandom());
    send_beat(OP_PREV, $urandom());
    send_beat(OP_PREV, $urandom());
    send_beat(OP_PREV, $urandom());
    send_beat(OP_CURRENT, $urandom());
    // remove at tail, at head, then the last one
    send_beat(OP_TAIL, $urandom());
    send_beat(OP_REMOVE, $urandom());
    send_beat(OP_HEAD, $urandom());
    send_beat(OP_REMOVE, $urandom());
    send_beat(OP_REMOVE, $urandom());
    send_beat(OP_CURRENT, $urandom());

    run_phase(100, 45, 20);
    // fill the pool and keep pushing past full
    run_phase(330, 92, 3);
    quiet = 1'b1;
    run_phase(80, 15, 5);
    quiet = 1'b0;
    // drain to empty and linger there
    run_phase(400, 10, 75);
    run_phase(90, 40, 30);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d beats, checked %0d results; peak length %0d of %0d entries.",
             sb.beats_in, sb.beats_out, sb.peak, POOL_DEPTH);
    $display("Refused inserts on a full pool: %0d; results with no entry: %0d.",
             sb.refused, sb.blank);
    if (sb.errors == 0) begin
      $display("tb_cursor_linked_list_engine passed");
    end else begin
      $display("tb_cursor_linked_list_engine failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/clle_pkg.sv
design/clle_ram.sv
design/clle_ctrl.sv
design/clle_obuf.sv
design/cursor_linked_list_engine.sv
design/clle_checker.sv
sim/tb_cursor_linked_list_engine.sv
